// ===== src/nci_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nci_pkg
// Shared types and constants for the nearest centroid interval predictor.
// ----------------------------------------------------------------------------
package nci_pkg;

  localparam int FEAT_W     = 16;
  localparam int NFEAT      = 4;
  localparam int SLOT_W     = 4;
  localparam int SUP_W      = 16;
  localparam int SQ_W       = 32;
  localparam int DIST_W     = 34;
  localparam int PRED_W     = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int CNT_W      = 5;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ERR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER = 3'd4;

  // positions in a stats vector
  localparam int STAT_KEY = 0;
  localparam int STAT_ERR = 1;
  localparam int STAT_UB  = 2;
  localparam int STAT_LB  = 3;

  typedef logic [NFEAT-1:0][FEAT_W-1:0] vec_t;

  typedef struct packed {
    logic                valid;
    logic                cmd;
    logic [SLOT_W-1:0]   slot;
    vec_t                feat;
    logic [SUP_W-1:0]    support;
    vec_t                stats;
    logic [FEAT_W-1:0]   target;
    logic [DIST_W-1:0]   best_dist;
    logic [SLOT_W-1:0]   best_idx;
    logic [SUP_W-1:0]    best_support;
    vec_t                best_stats;
  } item_t;

  typedef struct packed {
    logic              mode;
    logic [FEAT_W-1:0] err_mean;
    logic [FEAT_W-1:0] upper;
    logic [FEAT_W-1:0] lower;
  } glob_t;

endpackage

// ===== src/nci_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nci_cell
// One cluster entry of the search chain: squares stage, then sum and compare.
// ----------------------------------------------------------------------------
module nci_cell #(
  parameter int IDX  = 0,
  parameter int DIMS = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           active,
  input  nci_pkg::item_t in_item,
  output nci_pkg::item_t out_item
);
  import nci_pkg::*;

  localparam bit                IN_RANGE = (IDX < (2 ** SLOT_W));
  localparam bit                FIRST    = (IDX == 0);
  localparam logic [SLOT_W-1:0] CELL_IDX = SLOT_W'(IDX);

  // entry storage, written only by load words passing this cell
  vec_t             cent_r;
  logic [SUP_W-1:0] sup_r;
  vec_t             stats_r;

  item_t                      a_item_r;
  logic [NFEAT-1:0][SQ_W-1:0] a_sq_r, a_sq_nxt;
  logic [SUP_W-1:0]           a_sup_r;
  vec_t                       a_stats_r;
  item_t                      b_item_r, b_item_nxt;

  logic                    hit;
  logic signed [FEAT_W:0]  diff  [NFEAT];
  logic signed [2*FEAT_W+1:0] prod [NFEAT];
  logic [DIST_W-1:0]       sq_sum;
  logic                    take;

  assign hit = IN_RANGE && in_item.valid && (in_item.cmd == CMD_LOAD) &&
               (in_item.slot == CELL_IDX);

  always_comb begin
    for (int d = 0; d < NFEAT; d++) begin
      diff[d] = $signed({in_item.feat[d][FEAT_W-1], in_item.feat[d]}) -
                $signed({cent_r[d][FEAT_W-1], cent_r[d]});
      prod[d] = diff[d] * diff[d];
      a_sq_nxt[d] = (d < DIMS) ? prod[d][SQ_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && hit) begin
      cent_r  <= in_item.feat;
      sup_r   <= in_item.support;
      stats_r <= in_item.stats;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_item_r.valid <= 1'b0;
    end else if (adv) begin
      a_item_r  <= in_item;
      a_sq_r    <= a_sq_nxt;
      a_sup_r   <= sup_r;
      a_stats_r <= stats_r;
    end
  end

  always_comb begin
    sq_sum = DIST_W'(a_sq_r[0]) + DIST_W'(a_sq_r[1]) +
             DIST_W'(a_sq_r[2]) + DIST_W'(a_sq_r[3]);
    take = a_item_r.valid && (a_item_r.cmd == CMD_QUERY) && active &&
           (FIRST || (sq_sum < a_item_r.best_dist));
    b_item_nxt = a_item_r;
    if (take) begin
      b_item_nxt.best_dist    = sq_sum;
      b_item_nxt.best_idx     = CELL_IDX;
      b_item_nxt.best_support = a_sup_r;
      b_item_nxt.best_stats   = a_stats_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_item_r.valid <= 1'b0;
    end else if (adv) begin
      b_item_r <= b_item_nxt;
    end
  end

  assign out_item = b_item_r;

endmodule

// ===== src/nci_finish.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nci_finish
// Output stage: interval predictions, coverage flag and result register.
// ----------------------------------------------------------------------------
module nci_finish (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  nci_pkg::item_t                    in_item,
  input  nci_pkg::glob_t                    glob,
  output logic                              out_valid,
  output logic [nci_pkg::SLOT_W-1:0]        out_nearest_cluster,
  output logic [nci_pkg::SUP_W-1:0]         out_cluster_support,
  output logic signed [nci_pkg::PRED_W-1:0] out_low_prediction,
  output logic signed [nci_pkg::PRED_W-1:0] out_mid_prediction,
  output logic signed [nci_pkg::PRED_W-1:0] out_high_prediction,
  output logic                              out_target_covered
);
  import nci_pkg::*;

  logic                     valid_r;
  logic [SLOT_W-1:0]        idx_r;
  logic [SUP_W-1:0]         sup_r;
  logic signed [PRED_W-1:0] lo_r, mid_r, hi_r;
  logic                     cov_r;

  logic [FEAT_W-1:0]        em, ub, lb, key;
  logic signed [PRED_W-1:0] lo_nxt, mid_nxt, hi_nxt, tgt;
  logic                     cov_nxt;

  always_comb begin
    key = in_item.best_stats[STAT_KEY];
    if (glob.mode) begin
      em = glob.err_mean;
      ub = glob.upper;
      lb = glob.lower;
    end else begin
      em = in_item.best_stats[STAT_ERR];
      ub = in_item.best_stats[STAT_UB];
      lb = in_item.best_stats[STAT_LB];
    end
    lo_nxt  = $signed({key[FEAT_W-1], key}) - $signed({ub[FEAT_W-1], ub});
    mid_nxt = $signed({key[FEAT_W-1], key}) - $signed({em[FEAT_W-1], em});
    hi_nxt  = $signed({key[FEAT_W-1], key}) - $signed({lb[FEAT_W-1], lb});
    tgt     = $signed({in_item.target[FEAT_W-1], in_item.target});
    cov_nxt = (lo_nxt <= tgt) && (tgt <= hi_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_item.valid && (in_item.cmd == CMD_QUERY);
      idx_r   <= in_item.best_idx;
      sup_r   <= in_item.best_support;
      lo_r    <= lo_nxt;
      mid_r   <= mid_nxt;
      hi_r    <= hi_nxt;
      cov_r   <= cov_nxt;
    end
  end

  assign out_valid           = valid_r;
  assign out_nearest_cluster = idx_r;
  assign out_cluster_support = sup_r;
  assign out_low_prediction  = lo_r;
  assign out_mid_prediction  = mid_r;
  assign out_high_prediction = hi_r;
  assign out_target_covered  = cov_r;

endmodule

// ===== src/nearest_centroid_interval_predictor_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_centroid_interval_predictor_top
// Nearest centroid search over a chain of cluster cells, with interval
// predictions from per-cluster or global error statistics.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall   load or query word
//   out_     output     out_valid / out_stall result word (queries only)
//   cfg_     input      cfg_we               cfg_index, cfg_wdata
//
// One word enters per cycle while in_stall is low; each word passes the entry
// register, the cell chain (two stages per cluster) and the result register.
// Loads travel the chain and write their cell in order with queries.
// A stalled result freezes the whole chain; nothing is dropped or repeated.
// Synchronous active-low reset clears valid bits and glob_r, sets count_r to 16.
// ----------------------------------------------------------------------------
module nearest_centroid_interval_predictor_top #(
  parameter int CLUSTERS = 16,
  parameter int DIMS     = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_command,
  input  logic [nci_pkg::SLOT_W-1:0]           in_cluster_slot,
  input  logic signed [nci_pkg::FEAT_W-1:0]    in_feature_0,
  input  logic signed [nci_pkg::FEAT_W-1:0]    in_feature_1,
  input  logic signed [nci_pkg::FEAT_W-1:0]    in_feature_2,
  input  logic signed [nci_pkg::FEAT_W-1:0]    in_feature_3,
  input  logic [nci_pkg::SUP_W-1:0]            in_load_support,
  input  logic signed [nci_pkg::FEAT_W-1:0]    in_load_key_mean,
  input  logic signed [nci_pkg::FEAT_W-1:0]    in_load_err_mean,
  input  logic signed [nci_pkg::FEAT_W-1:0]    in_load_upper_bound,
  input  logic signed [nci_pkg::FEAT_W-1:0]    in_load_lower_bound,
  input  logic signed [nci_pkg::FEAT_W-1:0]    in_target_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [nci_pkg::SLOT_W-1:0]           out_nearest_cluster,
  output logic [nci_pkg::SUP_W-1:0]            out_cluster_support,
  output logic signed [nci_pkg::PRED_W-1:0]    out_low_prediction,
  output logic signed [nci_pkg::PRED_W-1:0]    out_mid_prediction,
  output logic signed [nci_pkg::PRED_W-1:0]    out_high_prediction,
  output logic                                 out_target_covered,
  input  logic                                 cfg_we,
  input  logic [nci_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [nci_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
  import nci_pkg::*;

  logic              adv;
  glob_t             glob_r;
  logic [CNT_W-1:0]  count_r;
  item_t             entry_r, entry_nxt;
  item_t             chain [CLUSTERS+1];
  logic [CLUSTERS-1:0] active;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glob_r  <= '0;
      count_r <= CNT_W'(16);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:  glob_r.mode     <= cfg_wdata[0];
        CFG_COUNT: count_r         <= cfg_wdata[CNT_W-1:0];
        CFG_ERR:   glob_r.err_mean <= cfg_wdata;
        CFG_UPPER: glob_r.upper    <= cfg_wdata;
        CFG_LOWER: glob_r.lower    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    entry_nxt              = '0;
    entry_nxt.valid        = in_valid;
    entry_nxt.cmd          = in_command;
    entry_nxt.slot         = in_cluster_slot;
    entry_nxt.feat[0]      = in_feature_0;
    entry_nxt.feat[1]      = in_feature_1;
    entry_nxt.feat[2]      = in_feature_2;
    entry_nxt.feat[3]      = in_feature_3;
    entry_nxt.support      = in_load_support;
    entry_nxt.stats[STAT_KEY] = in_load_key_mean;
    entry_nxt.stats[STAT_ERR] = in_load_err_mean;
    entry_nxt.stats[STAT_UB]  = in_load_upper_bound;
    entry_nxt.stats[STAT_LB]  = in_load_lower_bound;
    entry_nxt.target       = in_target_value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
    end else if (adv) begin
      entry_r <= entry_nxt;
    end
  end

  assign chain[0] = entry_r;

  for (genvar i = 0; i < CLUSTERS; i++) begin : g_cell
    // a count of zero still searches entry 0
    assign active[i] = (i == 0) || (int'(count_r) > i);

    nci_cell #(
      .IDX  (i),
      .DIMS (DIMS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .active   (active[i]),
      .in_item  (chain[i]),
      .out_item (chain[i+1])
    );
  end

  nci_finish u_finish (
    .clk                 (clk),
    .rst_n               (rst_n),
    .adv                 (adv),
    .in_item             (chain[CLUSTERS]),
    .glob                (glob_r),
    .out_valid           (out_valid),
    .out_nearest_cluster (out_nearest_cluster),
    .out_cluster_support (out_cluster_support),
    .out_low_prediction  (out_low_prediction),
    .out_mid_prediction  (out_mid_prediction),
    .out_high_prediction (out_high_prediction),
    .out_target_covered  (out_target_covered)
  );

`ifndef ASSERT_OFF
  a_rose_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |->
      $past(chain[CLUSTERS].valid && (chain[CLUSTERS].cmd == CMD_QUERY)))
    else $error("result appeared without a query leaving the chain");

  a_covered_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_target_covered) |-> (out_low_prediction <= out_high_prediction))
    else $error("covered flag set on an empty interval");

  a_freeze_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> ($stable(entry_r) && $stable(chain[CLUSTERS])))
    else $error("chain moved while the result was stalled");
`endif

endmodule
